/* rtl/core/stec_pkg.sv */
package stec_pkg;

    // Tree geometry: node 1 is the root, leaves sit at MAX_ELEMENTS .. 2*MAX_ELEMENTS-1.
    localparam int MAX_ELEMENTS = 1024;
    localparam int LEAF_W       = $clog2(MAX_ELEMENTS);
    localparam int NODE_W       = LEAF_W + 1;
    localparam int TREE_DEPTH   = 2 * MAX_ELEMENTS;
    // Query bounds may reach 2*MAX_ELEMENTS, one bit beyond a node address.
    localparam int QW           = NODE_W + 1;

    localparam logic [31:0] MAX_U = MAX_ELEMENTS;

    // Field widths fixed by the interface.
    localparam int CMD_W  = 2;
    localparam int POS_W  = 11;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 11;
    localparam int IN_W   = 72;
    localparam int OUT_W  = 16;

    localparam logic [POS_W-1:0] LEN_RESET = 11'd1024;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EVEN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ODD   = 2'd2;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic wr_leaf;
        logic rd_sib;
        logic wr_parent;
        logic q_lo;
        logic q_hi;
        logic out_load;
    } stec_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_write;
        logic is_query;
        logic wr_ok;
        logic q_empty;
        logic at_root;
        logic parent_root;
        logic q_more;
        logic out_free;
    } stec_stat_t;

endpackage

/* rtl/core/stec_ram.sv */
module stec_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/stec_dp.sv */
module stec_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  stec_pkg::stec_cmd_t       cmd,
    output stec_pkg::stec_stat_t      stat,
    input  logic [71:0]               s_axis_tdata,
    input  logic                      cfg_we,
    input  logic [10:0]               cfg_wdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [15:0]               m_axis_tdata
);

    import stec_pkg::*;

    logic [POS_W-1:0]  used_len_reg;
    logic [NODE_W-1:0] clr_addr_reg, clr_addr_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic              wr_ok_reg, empty_reg;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [CNT_W-1:0]  cur_reg, cur_next;
    logic [QW-1:0]     lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_W-1:0]  sum_reg, sum_next, len_reg;
    logic              pend_reg, pend_next;
    logic              out_valid_reg;
    logic [CNT_W-1:0]  out_data_reg;

    logic [CMD_W-1:0]  in_cmd;
    logic [POS_W-1:0]  in_pos, in_lo, in_hi, eff_len, q_lo, q_hi;
    logic [VAL_W-1:0]  in_val;
    logic [31:0]       leaf_w, lo_w, hi_w;
    logic [NODE_W-1:0] parent;
    logic [QW-1:0]     hi_dec;
    logic [CNT_W-1:0]  rdata, add_sum, result;
    logic              ram_we;
    logic [NODE_W-1:0] ram_waddr, ram_raddr;
    logic [CNT_W-1:0]  ram_wdata;

    assign in_cmd = s_axis_tdata[1:0];
    assign in_pos = s_axis_tdata[12:2];
    assign in_val = s_axis_tdata[44:13];
    assign in_lo  = s_axis_tdata[55:45];
    assign in_hi  = s_axis_tdata[66:56];

    always_comb
    begin
        if ({21'b0, used_len_reg} > MAX_U)
        begin
            eff_len = MAX_U[POS_W-1:0];
        end
        else
        begin
            eff_len = used_len_reg;
        end
        q_lo   = (in_lo == '0) ? POS_W'(1) : in_lo;
        q_hi   = (in_hi > eff_len) ? eff_len : in_hi;
        leaf_w = MAX_U + {21'b0, in_pos} - 32'd1;
        lo_w   = MAX_U + {21'b0, q_lo} - 32'd1;
        hi_w   = MAX_U + {21'b0, q_hi};
    end

    assign parent  = {1'b0, node_reg[NODE_W-1:1]};
    assign add_sum = cur_reg + rdata;
    assign hi_dec  = hi_reg - QW'(1);
    assign result  = empty_reg ? '0 :
                     ((cmd_reg == CMD_ODD) ? (len_reg - sum_reg) : sum_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_addr_reg;
        ram_wdata = '0;
        if (cmd.clr_step)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.wr_leaf)
        begin
            ram_we    = 1'b1;
            ram_waddr = node_reg;
            ram_wdata = cur_reg;
        end
        else if (cmd.wr_parent)
        begin
            ram_we    = 1'b1;
            ram_waddr = parent;
            ram_wdata = add_sum;
        end

        if (cmd.q_lo)
        begin
            ram_raddr = lo_reg[NODE_W-1:0];
        end
        else if (cmd.q_hi)
        begin
            ram_raddr = hi_dec[NODE_W-1:0];
        end
        else if (cmd.rd_sib)
        begin
            ram_raddr = node_reg ^ NODE_W'(1);
        end
        else
        begin
            ram_raddr = node_reg;
        end
    end

    stec_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TREE_DEPTH)
    ) u_tree (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        node_next     = node_reg;
        cur_next      = cur_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        pend_next     = 1'b0;
        sum_next      = sum_reg + (pend_reg ? rdata : '0);

        if (cmd.clr_step)
        begin
            clr_addr_next = clr_addr_reg + NODE_W'(1);
        end
        if (cmd.load)
        begin
            node_next = leaf_w[NODE_W-1:0];
            cur_next  = {{(CNT_W-1){1'b0}}, ~in_val[0]};
            lo_next   = lo_w[QW-1:0];
            hi_next   = hi_w[QW-1:0];
            sum_next  = '0;
        end
        if (cmd.wr_parent)
        begin
            node_next = parent;
            cur_next  = add_sum;
        end
        if (cmd.q_lo)
        begin
            pend_next = lo_reg[0];
            if (lo_reg[0])
            begin
                lo_next = lo_reg + QW'(1);
            end
        end
        if (cmd.q_hi)
        begin
            // Shift both bounds up one level once the right-hand node is taken.
            pend_next = hi_reg[0];
            lo_next   = {1'b0, lo_reg[QW-1:1]};
            if (hi_reg[0])
            begin
                hi_next = {1'b0, hi_dec[QW-1:1]};
            end
            else
            begin
                hi_next = {1'b0, hi_reg[QW-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_len_reg  <= LEN_RESET;
            clr_addr_reg  <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                used_len_reg <= cfg_wdata;
            end
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        cur_reg  <= cur_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        sum_reg  <= sum_next;
        if (cmd.load)
        begin
            cmd_reg   <= in_cmd;
            wr_ok_reg <= (in_pos != '0) && (in_pos <= eff_len);
            empty_reg <= q_lo > q_hi;
            len_reg   <= q_hi - q_lo + CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign stat.clr_last    = (clr_addr_reg == '1);
    assign stat.is_write    = (cmd_reg == CMD_WRITE);
    assign stat.is_query    = (cmd_reg == CMD_EVEN) || (cmd_reg == CMD_ODD);
    assign stat.wr_ok       = wr_ok_reg;
    assign stat.q_empty     = empty_reg;
    assign stat.at_root     = (node_reg == NODE_W'(1));
    assign stat.parent_root = (parent == NODE_W'(1));
    assign stat.q_more      = (lo_reg < hi_reg);
    assign stat.out_free    = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_data_reg};

endmodule

/* rtl/core/stec_ctrl.sv */
module stec_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  stec_pkg::stec_stat_t stat,
    output stec_pkg::stec_cmd_t  cmd
);

    import stec_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_DISPATCH = 9'b000000100,
        ST_W_LEAF   = 9'b000001000,
        ST_W_READ   = 9'b000010000,
        ST_W_ADD    = 9'b000100000,
        ST_Q_A      = 9'b001000000,
        ST_Q_B      = 9'b010000000,
        ST_Q_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.is_write)
                begin
                    state_next = stat.wr_ok ? ST_W_LEAF : ST_IDLE;
                end
                else if (stat.is_query)
                begin
                    state_next = stat.q_empty ? ST_Q_OUT : ST_Q_A;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_W_LEAF:
            begin
                cmd.wr_leaf = 1'b1;
                state_next  = stat.at_root ? ST_IDLE : ST_W_READ;
            end
            ST_W_READ:
            begin
                cmd.rd_sib = 1'b1;
                state_next = ST_W_ADD;
            end
            ST_W_ADD:
            begin
                cmd.wr_parent = 1'b1;
                state_next    = stat.parent_root ? ST_IDLE : ST_W_READ;
            end
            ST_Q_A:
            begin
                if (stat.q_more)
                begin
                    cmd.q_lo   = 1'b1;
                    state_next = ST_Q_B;
                end
                else
                begin
                    state_next = ST_Q_OUT;
                end
            end
            ST_Q_B:
            begin
                cmd.q_hi   = 1'b1;
                state_next = ST_Q_A;
            end
            ST_Q_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/segment_tree_even_count_core.sv */
// Even/odd counter over positions 1..MAX_ELEMENTS, held as a sum tree of
// "is even" bits in one block memory of 2*MAX_ELEMENTS nodes.
// The input stream carries one command per word: a write stores the parity of
// new_value at a position and gives no output word; an even or odd count over
// an inclusive range gives exactly one output word holding the count.
// Writes outside 1..min(used_length, MAX_ELEMENTS), and unused command codes,
// are dropped. used_length is set through cfg_we/cfg_wdata; the user must
// set it only while the block is idle, which the block does not enforce.
// A write stores the leaf bit; then each tree level needs one memory read of
// the sibling and one write of the parent through the single read and write port.
// A count walks both range bounds up the tree, the low bound and then the
// high bound at each of up to log2(MAX_ELEMENTS)+1 levels, after a set-up
// step; it then ends the walk and loads the output register, while an empty
// range goes straight to the output load. One command is worked on at a
// time; s_axis_tready is high only between commands. After reset the block
// clears the whole tree memory, all 2*MAX_ELEMENTS nodes, one node a cycle,
// before it accepts a word.
// A finished count sits in an output register; if the receiver stalls, the
// block still accepts the next command and only waits if that one also
// finishes a count before the earlier word has been taken.
module segment_tree_even_count_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // From bit 0: cmd[1:0], position[12:2], new_value[44:13],
    // range_low[55:45], range_high[66:56], zero padding [71:67].
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // From bit 0: count[10:0], zero padding [15:11].
    output logic [15:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata
);

    import stec_pkg::*;

    // The controller sequences the tree walks; the datapath owns the
    // memory, the bound and node registers and the output register.
    stec_cmd_t  cmd;
    stec_stat_t stat;

    stec_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    stec_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
